// ----- rtl/core/owbm_pkg.sv -----
// Shared types, constants and helpers for the 1-Wire bus master.
`default_nettype none
package owbm_pkg;

  // Config register width and tick timer width
  localparam int CFG_W   = 10;
  localparam int TIMER_W = 10;
  localparam int TMAX    = (1 << TIMER_W) - 1;
  localparam int CFG_IDX_W = 3;

  // Byte and bit counter sizes
  localparam int BYTE_W  = 8;
  localparam int BIT_W   = 3;
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BYTE_W - 1);

  // Command codes
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_SAMPLE = 3'd1,
    REG_RESET_REC   = 3'd2,
    REG_SHORT_LOW   = 3'd3,
    REG_ZERO_LOW    = 3'd4,
    REG_READ_SAMPLE = 3'd5,
    REG_SLOT        = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_RESET_LOW   = CFG_W'(480);
  localparam logic [CFG_W-1:0] RST_PRES_SAMPLE = CFG_W'(70);
  localparam logic [CFG_W-1:0] RST_RESET_REC   = CFG_W'(410);
  localparam logic [CFG_W-1:0] RST_SHORT_LOW   = CFG_W'(6);
  localparam logic [CFG_W-1:0] RST_ZERO_LOW    = CFG_W'(60);
  localparam logic [CFG_W-1:0] RST_READ_SAMPLE = CFG_W'(15);
  localparam logic [CFG_W-1:0] RST_SLOT        = CFG_W'(70);

  // Lowest usable counts
  localparam logic [CFG_W-1:0] MIN_TICKS      = CFG_W'(1);
  localparam logic [CFG_W-1:0] MIN_SLOT_TICKS = CFG_W'(2);

  // Bus phases
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_RLOW  = 5'b00010,
    PH_RWAIT = 5'b00100,
    PH_RREC  = 5'b01000,
    PH_SLOT  = 5'b10000
  } phase_t;

  // Effective (clamped) timing set
  typedef struct packed {
    logic [TIMER_W-1:0] reset_low;
    logic [TIMER_W-1:0] pres_sample;
    logic [TIMER_W-1:0] reset_rec;
    logic [TIMER_W-1:0] short_low;
    logic [TIMER_W-1:0] zero_low;
    logic [TIMER_W-1:0] read_sample;
    logic [TIMER_W-1:0] slot;
  } timing_t;

  // Clamp a count into [lo, TMAX]
  function automatic logic [TIMER_W-1:0] clamp_ticks(input logic [CFG_W-1:0] v,
                                                     input logic [CFG_W-1:0] lo);
    logic [CFG_W-1:0] r;
    r = (v < lo) ? lo : v;
    if (32'(r) > 32'(TMAX)) begin
      return TIMER_W'(TMAX);
    end
    return TIMER_W'(r);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/owbm_cfg.sv -----
// Timing register file with clamping to usable counts.
`default_nettype none
module owbm_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [owbm_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [owbm_pkg::CFG_W-1:0]    wr_data,
  output owbm_pkg::timing_t                  timing
);
  import owbm_pkg::*;

  logic [CFG_W-1:0] reset_low, pres_sample, reset_rec, short_low;
  logic [CFG_W-1:0] zero_low, read_sample, slot;
  logic [TIMER_W-1:0] slot_eff, samp_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low   <= RST_RESET_LOW;
      pres_sample <= RST_PRES_SAMPLE;
      reset_rec   <= RST_RESET_REC;
      short_low   <= RST_SHORT_LOW;
      zero_low    <= RST_ZERO_LOW;
      read_sample <= RST_READ_SAMPLE;
      slot        <= RST_SLOT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RESET_LOW:   reset_low   <= wr_data;
        REG_PRES_SAMPLE: pres_sample <= wr_data;
        REG_RESET_REC:   reset_rec   <= wr_data;
        REG_SHORT_LOW:   short_low   <= wr_data;
        REG_ZERO_LOW:    zero_low    <= wr_data;
        REG_READ_SAMPLE: read_sample <= wr_data;
        REG_SLOT:        slot        <= wr_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // sample point never lands past the last tick of the slot
  always_comb begin
    slot_eff = clamp_ticks(slot, MIN_SLOT_TICKS);
    samp_eff = clamp_ticks(read_sample, MIN_TICKS);
    if (samp_eff > slot_eff - TIMER_W'(1)) begin
      samp_eff = slot_eff - TIMER_W'(1);
    end
    timing.reset_low   = clamp_ticks(reset_low, MIN_TICKS);
    timing.pres_sample = clamp_ticks(pres_sample, MIN_TICKS);
    timing.reset_rec   = clamp_ticks(reset_rec, MIN_TICKS);
    timing.short_low   = clamp_ticks(short_low, MIN_TICKS);
    timing.zero_low    = clamp_ticks(zero_low, MIN_TICKS);
    timing.read_sample = samp_eff;
    timing.slot        = slot_eff;
  end

endmodule
`default_nettype wire

// ----- rtl/core/one_wire_bus_master.sv -----
// 1-Wire bus master: tick-driven sequencer for reset, write byte and read byte.
//
// Each input beat is one tick of the bus time base, carrying an optional
// command and the sampled DQ level; each input beat yields exactly one output
// beat with the drive_low request, busy/done flags, presence flag and the last
// read byte. A command is taken only while the sequencer is idle and its
// accepting tick is already its first tick; commands that arrive while busy
// are dropped. Bytes go LSB first, one slot per bit: a write-1 or read slot
// pulls low for short_low_ticks, a write-0 slot for zero_low_ticks; reads
// sample DQ at read_sample_ticks into the slot. Throughput is one beat per
// clock while out_stall does not hold the output: a beat sits in the input
// register, the next-state logic (one timer increment and compare per tick)
// runs combinationally, and the result lands in the output register. Stall on
// the output side backs up into in_stall with no beat lost. Timing registers
// are written over the cfg port (index 0..6, higher indexes ignored) and
// must only be changed while no command is in flight; cfg_ready is always 1.
`default_nettype none
module one_wire_bus_master (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // tick input channel
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [1:0]                      command,
  input  wire logic [owbm_pkg::BYTE_W-1:0]     write_data,
  input  wire logic                            line_level,
  // result channel
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic                            drive_low,
  output      logic                            busy_res,
  output      logic                            done_res,
  output      logic                            presence,
  output      logic [owbm_pkg::BYTE_W-1:0]     read_result,
  // config write channel
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [owbm_pkg::CFG_W-1:0]      cfg_data
);
  import owbm_pkg::*;

  timing_t timing;

  // input register
  logic              s1_valid;
  logic [1:0]        s1_cmd;
  logic [BYTE_W-1:0] s1_wdata;
  logic              s1_line;
  logic              in_take, advance;

  // sequencer state
  phase_t             phase, phase_next;
  cmd_t               operation, operation_next;
  logic [TIMER_W-1:0] slot_timer, slot_timer_next;
  logic [BIT_W-1:0]   bit_index, bit_index_next;
  logic [BYTE_W-1:0]  shift_byte, shift_byte_next;
  logic               presence_flag, presence_flag_next;
  logic [BYTE_W-1:0]  read_reg, read_reg_next;

  // per-tick work signals
  logic               start;
  phase_t             ph;
  logic [TIMER_W:0]   tmr_inc;
  logic [TIMER_W-1:0] low_len;
  logic               drive_next, busy_next, done_next;

  assign cfg_ready = 1'b1;

  owbm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .timing   (timing)
  );

  // handshake: stage 1 moves on when the output register is free or draining
  assign advance  = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & ~advance;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd   <= command;
      s1_wdata <= write_data;
      s1_line  <= line_level;
    end
  end

  // one tick of the sequencer
  always_comb begin
    start              = (phase == PH_IDLE) && (s1_cmd != CMD_NONE);
    ph                 = phase;
    operation_next     = operation;
    slot_timer_next    = slot_timer;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    read_reg_next      = read_reg;
    drive_next         = 1'b0;
    busy_next          = 1'b0;
    done_next          = 1'b0;
    low_len            = timing.short_low;

    // the accepting tick is already the first tick of the command
    if (start) begin
      operation_next  = cmd_t'(s1_cmd);
      slot_timer_next = '0;
      bit_index_next  = '0;
      shift_byte_next = (s1_cmd == CMD_WRITE) ? s1_wdata : '0;
      ph              = (s1_cmd == CMD_RESET) ? PH_RLOW : PH_SLOT;
    end
    phase_next = ph;
    tmr_inc    = {1'b0, slot_timer_next} + (TIMER_W+1)'(1);

    unique case (ph)
      PH_IDLE: ;
      PH_RLOW: begin
        busy_next  = 1'b1;
        drive_next = 1'b1;
        if (tmr_inc >= {1'b0, timing.reset_low}) begin
          phase_next      = PH_RWAIT;
          slot_timer_next = '0;
        end else begin
          slot_timer_next = tmr_inc[TIMER_W-1:0];
        end
      end
      PH_RWAIT: begin
        busy_next = 1'b1;
        if (tmr_inc >= {1'b0, timing.pres_sample}) begin
          presence_flag_next = ~s1_line;  // device holds DQ low
          phase_next         = PH_RREC;
          slot_timer_next    = '0;
        end else begin
          slot_timer_next = tmr_inc[TIMER_W-1:0];
        end
      end
      PH_RREC: begin
        busy_next = 1'b1;
        if (tmr_inc >= {1'b0, timing.reset_rec}) begin
          done_next       = 1'b1;
          phase_next      = PH_IDLE;
          slot_timer_next = '0;
        end else begin
          slot_timer_next = tmr_inc[TIMER_W-1:0];
        end
      end
      PH_SLOT: begin
        busy_next = 1'b1;
        if (operation_next == CMD_WRITE && !shift_byte_next[0]) begin
          low_len = timing.zero_low;
        end
        drive_next = (slot_timer_next < low_len);
        if (operation_next == CMD_READ && slot_timer_next == timing.read_sample) begin
          shift_byte_next = {s1_line, shift_byte_next[BYTE_W-1:1]};
        end
        if (tmr_inc >= {1'b0, timing.slot}) begin
          if (operation_next == CMD_WRITE) begin
            shift_byte_next = {1'b0, shift_byte_next[BYTE_W-1:1]};
          end
          slot_timer_next = '0;
          if (bit_index_next == BIT_LAST) begin
            done_next = 1'b1;
            if (operation_next == CMD_READ) begin
              read_reg_next = shift_byte_next;
            end
            phase_next     = PH_IDLE;
            bit_index_next = '0;
          end else begin
            bit_index_next = bit_index_next + BIT_W'(1);
          end
        end else begin
          slot_timer_next = tmr_inc[TIMER_W-1:0];
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      operation     <= CMD_NONE;
      slot_timer    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      read_reg      <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      operation     <= operation_next;
      slot_timer    <= slot_timer_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      read_reg      <= read_reg_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_low   <= drive_next;
      busy_res    <= busy_next;
      done_res    <= done_next;
      presence    <= presence_flag_next;
      read_result <= read_reg_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/owbm_checker.sv -----
// Port-level checks for the 1-Wire bus master, bound to the top level.
`default_nettype none
module owbm_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            drive_low,
  input wire logic                            busy_res,
  input wire logic                            done_res,
  input wire logic                            presence,
  input wire logic [owbm_pkg::BYTE_W-1:0]     read_result
);

  // bus is only pulled while a command runs
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_low |-> busy_res)
    else $error("drive_low without busy");

  // done only on a tick of a command
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> busy_res)
    else $error("done without busy");

  // no result beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_low) && $stable(busy_res)
      && $stable(done_res) && $stable(presence) && $stable(read_result))
    else $error("stalled result beat changed");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (.*);
`default_nettype wire
